// ===== design/rpt_pkg.sv =====
// Package for the route prefix table: sizes, command and status codes,
// the stored entry layout and the memory request bundle.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package rpt_pkg;

  localparam int ROUTE_ENTRIES = 64;
  localparam int IDX_W         = $clog2(ROUTE_ENTRIES);
  localparam int CNT_W         = $clog2(ROUTE_ENTRIES + 1);

  localparam int CMD_W         = 2;
  localparam int ADDR_W        = 32;
  localparam int POS_W         = 6;
  localparam int STATUS_W      = 3;
  localparam int COUNT_OUT_W   = 7;

  typedef enum logic [CMD_W-1:0] {
    CMD_ADD    = 2'd0,
    CMD_ERASE  = 2'd1,
    CMD_LOOKUP = 2'd2,
    CMD_NOP    = 2'd3
  } cmd_e;

  typedef enum logic [STATUS_W-1:0] {
    STAT_OK        = 3'd0,
    STAT_FULL      = 3'd1,
    STAT_NO_POS    = 3'd2,
    STAT_PROTECTED = 3'd3,
    STAT_NO_ROUTE  = 3'd4
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_ADD,
    S_ERASE,
    S_LOOKUP
  } state_e;

  typedef struct packed {
    logic [ADDR_W-1:0] net;
    logic [ADDR_W-1:0] mask;
    logic [ADDR_W-1:0] hop;
    logic              direct;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  typedef struct packed {
    logic             we;
    logic [IDX_W-1:0] waddr;
    entry_t           wdata;
    logic             re;
    logic [IDX_W-1:0] raddr;
  } mem_req_t;

endpackage

`default_nettype wire

// ===== design/rpt_ram.sv =====
// Generic simple dual-port RAM with one write port and one registered read port.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module rpt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ===== design/rpt_ctrl.sv =====
// Sequencer of the route prefix table: insertion, erase shift and lookup scan
// over the entry memory, with the result register. Uses rpt_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rpt_ctrl (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            start_i,
  output logic                                 busy_o,
  input  wire logic [rpt_pkg::CMD_W-1:0]       cmd_i,
  input  wire logic [rpt_pkg::ADDR_W-1:0]      route_net_i,
  input  wire logic [rpt_pkg::ADDR_W-1:0]      route_mask_i,
  input  wire logic [rpt_pkg::ADDR_W-1:0]      route_next_hop_i,
  input  wire logic                            route_direct_i,
  input  wire logic [rpt_pkg::POS_W-1:0]       erase_position_i,
  input  wire logic [rpt_pkg::ADDR_W-1:0]      lookup_addr_i,
  output rpt_pkg::mem_req_t                    mem_req_o,
  input  wire rpt_pkg::entry_t                 mem_rdata_i,
  output logic                                 done_o,
  output logic [rpt_pkg::STATUS_W-1:0]         status_o,
  output logic [rpt_pkg::ADDR_W-1:0]           hop_addr_o,
  output logic [rpt_pkg::COUNT_OUT_W-1:0]      entry_count_o
);

  rpt_pkg::state_e                 state_q, state_d;
  logic [rpt_pkg::CNT_W-1:0]       used_q, used_d;
  logic [rpt_pkg::CNT_W-1:0]       ptr_q, ptr_d;
  logic [rpt_pkg::IDX_W-1:0]       pidx_q, pidx_d;
  logic                            pend_q, pend_d;
  logic                            first_q, first_d;
  logic                            done_q, done_d;
  rpt_pkg::status_e                status_q, status_d;
  logic [rpt_pkg::ADDR_W-1:0]      hop_q, hop_d;
  rpt_pkg::entry_t                 arg_q;
  logic [rpt_pkg::ADDR_W-1:0]      addr_q;

  logic [rpt_pkg::CNT_W-1:0]       ptr_dec;
  logic [rpt_pkg::CNT_W-1:0]       pos_ext;
  logic                            hit;

  assign ptr_dec = ptr_q - rpt_pkg::CNT_W'(1);
  assign pos_ext = rpt_pkg::CNT_W'(erase_position_i);
  assign hit     = (mem_rdata_i.mask & addr_q) == mem_rdata_i.net;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= rpt_pkg::S_IDLE;
      used_q   <= '0;
      ptr_q    <= '0;
      pidx_q   <= '0;
      pend_q   <= 1'b0;
      first_q  <= 1'b0;
      done_q   <= 1'b0;
      status_q <= rpt_pkg::STAT_OK;
      hop_q    <= '0;
    end else begin
      state_q  <= state_d;
      used_q   <= used_d;
      ptr_q    <= ptr_d;
      pidx_q   <= pidx_d;
      pend_q   <= pend_d;
      first_q  <= first_d;
      done_q   <= done_d;
      status_q <= status_d;
      hop_q    <= hop_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i && state_q == rpt_pkg::S_IDLE) begin
      arg_q.net    <= route_net_i;
      arg_q.mask   <= route_mask_i;
      arg_q.hop    <= route_next_hop_i;
      arg_q.direct <= route_direct_i;
      addr_q       <= lookup_addr_i;
    end
  end

  always_comb begin
    state_d   = state_q;
    used_d    = used_q;
    ptr_d     = ptr_q;
    pidx_d    = pidx_q;
    pend_d    = pend_q;
    first_d   = first_q;
    done_d    = 1'b0;
    status_d  = status_q;
    hop_d     = hop_q;
    mem_req_o = '0;

    unique case (state_q)
      rpt_pkg::S_IDLE: begin
        if (start_i) begin
          pend_d   = 1'b0;
          first_d  = 1'b1;
          hop_d    = '0;
          status_d = rpt_pkg::STAT_OK;
          unique case (rpt_pkg::cmd_e'(cmd_i))
            rpt_pkg::CMD_ADD: begin
              if (used_q == rpt_pkg::CNT_W'(rpt_pkg::ROUTE_ENTRIES)) begin
                done_d   = 1'b1;
                status_d = rpt_pkg::STAT_FULL;
              end else begin
                ptr_d   = used_q;
                state_d = rpt_pkg::S_ADD;
              end
            end
            rpt_pkg::CMD_ERASE: begin
              if (pos_ext >= used_q) begin
                done_d   = 1'b1;
                status_d = rpt_pkg::STAT_NO_POS;
              end else begin
                ptr_d   = pos_ext;
                state_d = rpt_pkg::S_ERASE;
              end
            end
            rpt_pkg::CMD_LOOKUP: begin
              ptr_d   = '0;
              state_d = rpt_pkg::S_LOOKUP;
            end
            rpt_pkg::CMD_NOP: begin
              done_d = 1'b1;
            end
            default: begin
              done_d = 1'b1;
            end
          endcase
        end
      end

      // Walk down from the top, moving each entry whose mask value is below the new one up by one.
      rpt_pkg::S_ADD: begin
        if (pend_q && mem_rdata_i.mask >= arg_q.mask) begin
          mem_req_o.we    = 1'b1;
          mem_req_o.waddr = pidx_q + rpt_pkg::IDX_W'(1);
          mem_req_o.wdata = arg_q;
          used_d          = used_q + rpt_pkg::CNT_W'(1);
          done_d          = 1'b1;
          state_d         = rpt_pkg::S_IDLE;
        end else if (pend_q) begin
          mem_req_o.we    = 1'b1;
          mem_req_o.waddr = pidx_q + rpt_pkg::IDX_W'(1);
          mem_req_o.wdata = mem_rdata_i;
          if (ptr_q != '0) begin
            mem_req_o.re    = 1'b1;
            mem_req_o.raddr = ptr_dec[rpt_pkg::IDX_W-1:0];
            pidx_d          = ptr_dec[rpt_pkg::IDX_W-1:0];
            ptr_d           = ptr_dec;
          end else begin
            pend_d = 1'b0;
          end
        end else if (ptr_q != '0) begin
          mem_req_o.re    = 1'b1;
          mem_req_o.raddr = ptr_dec[rpt_pkg::IDX_W-1:0];
          pidx_d          = ptr_dec[rpt_pkg::IDX_W-1:0];
          ptr_d           = ptr_dec;
          pend_d          = 1'b1;
        end else begin
          mem_req_o.we    = 1'b1;
          mem_req_o.waddr = '0;
          mem_req_o.wdata = arg_q;
          used_d          = used_q + rpt_pkg::CNT_W'(1);
          done_d          = 1'b1;
          state_d         = rpt_pkg::S_IDLE;
        end
      end

      // The first entry read is the victim; later entries move down by one.
      rpt_pkg::S_ERASE: begin
        if (pend_q && first_q && mem_rdata_i.direct) begin
          status_d = rpt_pkg::STAT_PROTECTED;
          done_d   = 1'b1;
          pend_d   = 1'b0;
          state_d  = rpt_pkg::S_IDLE;
        end else begin
          if (pend_q && first_q) begin
            first_d = 1'b0;
          end else if (pend_q) begin
            mem_req_o.we    = 1'b1;
            mem_req_o.waddr = pidx_q - rpt_pkg::IDX_W'(1);
            mem_req_o.wdata = mem_rdata_i;
          end
          if (ptr_q < used_q) begin
            mem_req_o.re    = 1'b1;
            mem_req_o.raddr = ptr_q[rpt_pkg::IDX_W-1:0];
            pidx_d          = ptr_q[rpt_pkg::IDX_W-1:0];
            ptr_d           = ptr_q + rpt_pkg::CNT_W'(1);
            pend_d          = 1'b1;
          end else begin
            used_d  = used_q - rpt_pkg::CNT_W'(1);
            done_d  = 1'b1;
            pend_d  = 1'b0;
            state_d = rpt_pkg::S_IDLE;
          end
        end
      end

      rpt_pkg::S_LOOKUP: begin
        if (pend_q && hit) begin
          hop_d   = mem_rdata_i.direct ? addr_q : mem_rdata_i.hop;
          done_d  = 1'b1;
          pend_d  = 1'b0;
          state_d = rpt_pkg::S_IDLE;
        end else if (ptr_q < used_q) begin
          mem_req_o.re    = 1'b1;
          mem_req_o.raddr = ptr_q[rpt_pkg::IDX_W-1:0];
          ptr_d           = ptr_q + rpt_pkg::CNT_W'(1);
          pend_d          = 1'b1;
        end else begin
          hop_d    = '1;
          status_d = rpt_pkg::STAT_NO_ROUTE;
          done_d   = 1'b1;
          pend_d   = 1'b0;
          state_d  = rpt_pkg::S_IDLE;
        end
      end

      default: begin
        state_d = rpt_pkg::S_IDLE;
      end
    endcase
  end

  assign busy_o        = state_q != rpt_pkg::S_IDLE;
  assign done_o        = done_q;
  assign status_o      = status_q;
  assign hop_addr_o    = hop_q;
  assign entry_count_o = rpt_pkg::COUNT_OUT_W'(used_q);

endmodule

`default_nettype wire

// ===== design/route_prefix_table.sv =====
// Route prefix table: an add walks down the entries above its slot, an erase walks up from the
// position and a lookup scans until its first match, with at most one entry read and one write per cycle.
// Full, missing-position and unused commands are answered from idle without a memory walk.
// One item at a time; busy is high while an add, erase or lookup is in progress.
// The result is shown for one cycle on done_o after the item ends; it cannot be stalled.
// Reset empties the table at once; no clearing pass is needed.
`timescale 1ns / 1ps
`default_nettype none

module route_prefix_table (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            start,
  output logic                                 busy,
  input  wire logic [rpt_pkg::CMD_W-1:0]       cmd_i,
  input  wire logic [rpt_pkg::ADDR_W-1:0]      route_net_i,
  input  wire logic [rpt_pkg::ADDR_W-1:0]      route_mask_i,
  input  wire logic [rpt_pkg::ADDR_W-1:0]      route_next_hop_i,
  input  wire logic                            route_direct_i,
  input  wire logic [rpt_pkg::POS_W-1:0]       erase_position_i,
  input  wire logic [rpt_pkg::ADDR_W-1:0]      lookup_addr_i,
  output logic                                 done_o,
  output logic [rpt_pkg::STATUS_W-1:0]         status_o,
  output logic [rpt_pkg::ADDR_W-1:0]           hop_addr_o,
  output logic [rpt_pkg::COUNT_OUT_W-1:0]      entry_count_o
);

  rpt_pkg::mem_req_t mem_req;
  rpt_pkg::entry_t   mem_rdata;

  rpt_ram #(
    .WIDTH (rpt_pkg::ENTRY_W),
    .DEPTH (rpt_pkg::ROUTE_ENTRIES)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (mem_req.we),
    .waddr_i (mem_req.waddr),
    .wdata_i (mem_req.wdata),
    .re_i    (mem_req.re),
    .raddr_i (mem_req.raddr),
    .rdata_o (mem_rdata)
  );

  rpt_ctrl u_ctrl (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .start_i          (start),
    .busy_o           (busy),
    .cmd_i            (cmd_i),
    .route_net_i      (route_net_i),
    .route_mask_i     (route_mask_i),
    .route_next_hop_i (route_next_hop_i),
    .route_direct_i   (route_direct_i),
    .erase_position_i (erase_position_i),
    .lookup_addr_i    (lookup_addr_i),
    .mem_req_o        (mem_req),
    .mem_rdata_i      (mem_rdata),
    .done_o           (done_o),
    .status_o         (status_o),
    .hop_addr_o       (hop_addr_o),
    .entry_count_o    (entry_count_o)
  );

endmodule

`default_nettype wire

// ===== tb/route_prefix_checker.sv =====
// Checker for the route prefix table: watches the command and result transfers,
// keeps its own copy of the routing table and compares every result in order.
// Depends on rpt_pkg for sizes, command and status codes and the entry layout.
`timescale 1ns / 1ps

module route_prefix_checker
  import rpt_pkg::*;
(
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   start,
  input  wire logic                   busy,
  input  wire logic [CMD_W-1:0]       cmd_i,
  input  wire logic [ADDR_W-1:0]      route_net_i,
  input  wire logic [ADDR_W-1:0]      route_mask_i,
  input  wire logic [ADDR_W-1:0]      route_next_hop_i,
  input  wire logic                   route_direct_i,
  input  wire logic [POS_W-1:0]       erase_position_i,
  input  wire logic [ADDR_W-1:0]      lookup_addr_i,
  input  wire logic                   done_o,
  input  wire logic [STATUS_W-1:0]    status_o,
  input  wire logic [ADDR_W-1:0]      hop_addr_o,
  input  wire logic [COUNT_OUT_W-1:0] entry_count_o,
  output int                          fail_count,
  output int                          pending_replies,
  output int                          route_count
);

  typedef struct packed {
    logic [STATUS_W-1:0]    status;
    logic [ADDR_W-1:0]      hop;
    logic [COUNT_OUT_W-1:0] count;
  } route_reply_t;

  entry_t       route_tbl [ROUTE_ENTRIES];
  int           tbl_used    = 0;
  int           fail_total  = 0;
  int           mismatches  = 0;
  route_reply_t reply_q [$];
  route_reply_t oldest_reply;

  assign fail_count      = fail_total;
  assign pending_replies = reply_q.size();
  assign route_count     = tbl_used;

  function automatic route_reply_t predict_route_reply(
    input cmd_e              c,
    input logic [ADDR_W-1:0] net,
    input logic [ADDR_W-1:0] mask,
    input logic [ADDR_W-1:0] hop,
    input logic              direct,
    input logic [POS_W-1:0]  pos,
    input logic [ADDR_W-1:0] addr
  );
    route_reply_t r;
    int           i;
    int           at;
    r.status = STAT_OK;
    r.hop    = '0;
    case (c)
      CMD_ADD: begin
        if (tbl_used >= ROUTE_ENTRIES) begin
          r.status = STAT_FULL;
        end else begin
          at = 0;
          while (at < tbl_used && route_tbl[at].mask >= mask) at++;
          for (i = tbl_used; i > at; i--) route_tbl[i] = route_tbl[i-1];
          route_tbl[at] = '{net: net, mask: mask, hop: hop, direct: direct};
          tbl_used++;
        end
      end
      CMD_ERASE: begin
        if (int'(pos) >= tbl_used) begin
          r.status = STAT_NO_POS;
        end else if (route_tbl[pos].direct) begin
          r.status = STAT_PROTECTED;
        end else begin
          for (i = int'(pos); i + 1 < tbl_used; i++) route_tbl[i] = route_tbl[i+1];
          tbl_used--;
        end
      end
      CMD_LOOKUP: begin
        r.status = STAT_NO_ROUTE;
        r.hop    = '1;
        for (i = 0; i < tbl_used; i++) begin
          if ((route_tbl[i].mask & addr) == route_tbl[i].net) begin
            r.status = STAT_OK;
            r.hop    = route_tbl[i].direct ? addr : route_tbl[i].hop;
            break;
          end
        end
      end
      default: begin
      end
    endcase
    r.count = COUNT_OUT_W'(tbl_used);
    return r;
  endfunction

  // The command transfer is taken first, so a result that shares its edge still
  // finds its expectation queued.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (start && !busy) begin
        reply_q.push_back(predict_route_reply(cmd_e'(cmd_i), route_net_i, route_mask_i,
                                              route_next_hop_i, route_direct_i,
                                              erase_position_i, lookup_addr_i));
      end
      if (done_o) begin
        if (reply_q.size() == 0) begin
          fail_total++;
          mismatches++;
          if (mismatches <= 10) begin
            $display("unexpected result: status %0d hop %h count %0d",
                     status_o, hop_addr_o, entry_count_o);
          end
        end else begin
          oldest_reply = reply_q.pop_front();
          if (oldest_reply.status !== status_o || oldest_reply.hop !== hop_addr_o ||
              oldest_reply.count !== entry_count_o) begin
            fail_total++;
            mismatches++;
            if (mismatches <= 10) begin
              $display("mismatch: expected status %0d hop %h count %0d, got status %0d hop %h count %0d",
                       oldest_reply.status, oldest_reply.hop, oldest_reply.count,
                       status_o, hop_addr_o, entry_count_o);
            end
          end
        end
      end
    end
  end

endmodule

// ===== tb/tb_top.sv =====
// Testbench top for the route prefix table: drives directed and random route
// commands, instantiates the block and route_prefix_checker, and gives the verdict.
// Depends on rpt_pkg, route_prefix_table and route_prefix_checker.
`timescale 1ns / 1ps

module tb_top;
  import rpt_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;

  typedef enum int {
    MIX_GROW,
    MIX_SHRINK,
    MIX_BALANCED
  } mix_e;

  logic                   clk_i;
  logic                   rst_ni;
  logic                   start;
  logic                   busy;
  logic [CMD_W-1:0]       cmd_i;
  logic [ADDR_W-1:0]      route_net_i;
  logic [ADDR_W-1:0]      route_mask_i;
  logic [ADDR_W-1:0]      route_next_hop_i;
  logic                   route_direct_i;
  logic [POS_W-1:0]       erase_position_i;
  logic [ADDR_W-1:0]      lookup_addr_i;
  logic                   done_o;
  logic [STATUS_W-1:0]    status_o;
  logic [ADDR_W-1:0]      hop_addr_o;
  logic [COUNT_OUT_W-1:0] entry_count_o;
  int                     fail_count;
  int                     pending_replies;
  int                     route_count;
  int                     idle_cycles;

  route_prefix_table u_top (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .start            (start),
    .busy             (busy),
    .cmd_i            (cmd_i),
    .route_net_i      (route_net_i),
    .route_mask_i     (route_mask_i),
    .route_next_hop_i (route_next_hop_i),
    .route_direct_i   (route_direct_i),
    .erase_position_i (erase_position_i),
    .lookup_addr_i    (lookup_addr_i),
    .done_o           (done_o),
    .status_o         (status_o),
    .hop_addr_o       (hop_addr_o),
    .entry_count_o    (entry_count_o)
  );

  route_prefix_checker u_checker (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .start            (start),
    .busy             (busy),
    .cmd_i            (cmd_i),
    .route_net_i      (route_net_i),
    .route_mask_i     (route_mask_i),
    .route_next_hop_i (route_next_hop_i),
    .route_direct_i   (route_direct_i),
    .erase_position_i (erase_position_i),
    .lookup_addr_i    (lookup_addr_i),
    .done_o           (done_o),
    .status_o         (status_o),
    .hop_addr_o       (hop_addr_o),
    .entry_count_o    (entry_count_o),
    .fail_count       (fail_count),
    .pending_replies  (pending_replies),
    .route_count      (route_count)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Called at a falling edge; returns at the falling edge after the transfer.
  task automatic send_route_cmd(
    input cmd_e              c,
    input logic [ADDR_W-1:0] net,
    input logic [ADDR_W-1:0] mask,
    input logic [ADDR_W-1:0] hop,
    input logic              direct,
    input logic [POS_W-1:0]  pos,
    input logic [ADDR_W-1:0] addr
  );
    cmd_i            <= c;
    route_net_i      <= net;
    route_mask_i     <= mask;
    route_next_hop_i <= hop;
    route_direct_i   <= direct;
    erase_position_i <= pos;
    lookup_addr_i    <= addr;
    start            <= 1'b1;
    do @(posedge clk_i); while (busy);
    @(negedge clk_i);
  endtask

  task automatic idle_gap(input int cycles);
    if (cycles > 0) begin
      start <= 1'b0;
      repeat (cycles) @(negedge clk_i);
    end
  endtask

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 92) return $urandom_range(1, 4);
    return $urandom_range(12, 48);
  endfunction

  initial begin
    idle_cycles = 0;
    while (idle_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk_i);
      if (!rst_ni || (start && !busy) || done_o) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
    end
    $display("TEST FAILED");
    $finish;
  end

  initial begin
    cmd_e              c;
    mix_e              mix;
    bit                quiet;
    int                r;
    int                ph;
    logic [ADDR_W-1:0] net;
    logic [ADDR_W-1:0] mask;
    logic [ADDR_W-1:0] hop;
    logic              direct;
    logic [POS_W-1:0]  pos;
    logic [ADDR_W-1:0] addr;
    logic [63:0]       pick;
    logic [63:0]       known_routes [$];

    rst_ni           = 1'b0;
    start            = 1'b0;
    cmd_i            = '0;
    route_net_i      = '0;
    route_mask_i     = '0;
    route_next_hop_i = '0;
    route_direct_i   = 1'b0;
    erase_position_i = '0;
    lookup_addr_i    = '0;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Empty table: no route, no such position, and the unused command.
    send_route_cmd(CMD_LOOKUP, '0, '0, '0, 1'b0, '0, 32'hFFFF_FFFF);
    send_route_cmd(CMD_ERASE, '0, '0, '0, 1'b0, 6'd0, '0);
    send_route_cmd(CMD_NOP, '0, '0, '0, 1'b0, '0, '0);
    // Default route, equal masks, a direct route, a host route, a network with
    // host bits set and a non-contiguous mask.
    send_route_cmd(CMD_ADD, 32'h0000_0000, 32'h0000_0000, 32'h0A0A_0A01, 1'b0, '0, '0);
    send_route_cmd(CMD_ADD, 32'hC0A8_0000, 32'hFFFF_0000, 32'hC0A8_00FE, 1'b0, '0, '0);
    send_route_cmd(CMD_ADD, 32'h0A00_0000, 32'hFF00_0000, 32'h0000_0000, 1'b1, '0, '0);
    send_route_cmd(CMD_ADD, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFE, 1'b0, '0, '0);
    send_route_cmd(CMD_ADD, 32'hC0A9_0000, 32'hFFFF_0000, 32'h0000_0001, 1'b0, '0, '0);
    send_route_cmd(CMD_ADD, 32'h0A00_00FF, 32'hFFFF_FF00, 32'h0000_0002, 1'b0, '0, '0);
    send_route_cmd(CMD_ADD, 32'h0A00_0A00, 32'hFF00_FF00, 32'h0000_0003, 1'b0, '0, '0);
    send_route_cmd(CMD_LOOKUP, '0, '0, '0, 1'b0, '0, 32'hC0A8_1234);
    send_route_cmd(CMD_LOOKUP, '0, '0, '0, 1'b0, '0, 32'hC0A9_0001);
    send_route_cmd(CMD_LOOKUP, '0, '0, '0, 1'b0, '0, 32'h0A01_0203);
    send_route_cmd(CMD_LOOKUP, '0, '0, '0, 1'b0, '0, 32'h0A00_00FF);
    send_route_cmd(CMD_LOOKUP, '0, '0, '0, 1'b0, '0, 32'hFFFF_FFFF);
    send_route_cmd(CMD_LOOKUP, '0, '0, '0, 1'b0, '0, 32'h0A55_0A77);
    send_route_cmd(CMD_LOOKUP, '0, '0, '0, 1'b0, '0, 32'h1234_5678);
    send_route_cmd(CMD_LOOKUP, '0, '0, '0, 1'b0, '0, 32'h0000_0000);
    send_route_cmd(CMD_ERASE, '0, '0, '0, 1'b0, 6'd63, '0);
    send_route_cmd(CMD_ERASE, '0, '0, '0, 1'b0, 6'd0, '0);
    send_route_cmd(CMD_ERASE, '0, '0, '0, 1'b0, 6'd4, '0);
    send_route_cmd(CMD_ERASE, '0, '0, '0, 1'b0, 6'd5, '0);
    send_route_cmd(CMD_LOOKUP, '0, '0, '0, 1'b0, '0, 32'h1234_5678);

    // Phases that fill the table up to full, drain it again, and mix both.
    for (ph = 0; ph < 8; ph++) begin
      mix   = mix_e'(ph % 3);
      quiet = (ph == 2 || ph == 5);
      repeat (94) begin
        r = $urandom_range(0, 99);
        case (mix)
          MIX_GROW:   c = r < 75 ? CMD_ADD : r < 80 ? CMD_ERASE : r < 98 ? CMD_LOOKUP : CMD_NOP;
          MIX_SHRINK: c = r < 10 ? CMD_ADD : r < 75 ? CMD_ERASE : r < 98 ? CMD_LOOKUP : CMD_NOP;
          default:    c = r < 35 ? CMD_ADD : r < 60 ? CMD_ERASE : r < 97 ? CMD_LOOKUP : CMD_NOP;
        endcase
        net    = $urandom;
        mask   = $urandom;
        hop    = $urandom;
        direct = 1'($urandom_range(0, 1));
        pos    = POS_W'($urandom);
        addr   = $urandom;
        if (c == CMD_ADD) begin
          r = $urandom_range(0, 99);
          if (r < 55) begin
            mask = 32'hFFFF_FFFF << (32 - 8 * $urandom_range(0, 4));
          end else if (r < 88) begin
            mask = 32'hFFFF_FFFF << (32 - $urandom_range(1, 31));
          end
          if ($urandom_range(0, 1)) net[31:16] = {8'd10, 6'd0, 2'($urandom_range(0, 3))};
          if ($urandom_range(0, 99) < 88) net &= mask;
          direct = ($urandom_range(0, 99) < 15);
          known_routes.push_back({net, mask});
          if (known_routes.size() > 32) void'(known_routes.pop_front());
        end
        if (c == CMD_ERASE && route_count > 0 && $urandom_range(0, 99) < 85) begin
          pos = POS_W'($urandom_range(0, route_count - 1));
        end
        if (c == CMD_LOOKUP) begin
          r = $urandom_range(0, 99);
          if (r < 70 && known_routes.size() > 0) begin
            pick = known_routes[$urandom_range(0, known_routes.size() - 1)];
            addr = (pick[63:32] & pick[31:0]) | ($urandom & ~pick[31:0]);
          end else if (r < 78) begin
            addr = $urandom_range(0, 1) ? '1 : '0;
          end
        end
        send_route_cmd(c, net, mask, hop, direct, pos, addr);
        idle_gap(quiet ? 0 : pick_gap());
      end
    end

    start <= 1'b0;
    while (pending_replies != 0) @(negedge clk_i);
    repeat (80) @(negedge clk_i);
    if (fail_count == 0 && pending_replies == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
design/rpt_pkg.sv
design/rpt_ram.sv
design/rpt_ctrl.sv
design/route_prefix_table.sv
tb/route_prefix_checker.sv
tb/tb_top.sv
